/* sv/qdec_pkg.sv */
// Shared types and constants for the dual quadrature decoder.
package qdec_pkg;

  // Request codes; code 3 is unused and changes nothing.
  localparam logic [1:0] REQ_PIN  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_INIT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LEFT_REVERSE  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_REVERSE = 2'd1;

  // Step for each {old AB, new AB}; A is the high bit of each pair.
  localparam logic signed [1:0] STEP_TABLE [16] = '{
     2'sb00,  2'sb11,  2'sb01,  2'sb00,
     2'sb01,  2'sb00,  2'sb00,  2'sb11,
     2'sb11,  2'sb00,  2'sb00,  2'sb01,
     2'sb00,  2'sb01,  2'sb11,  2'sb00
  };

  // Strobes to one side decoder, at most one set in a cycle.
  typedef struct packed {
    logic pin_event;
    logic tick;
    logic init;
  } side_ctl_t;

endpackage

/* sv/qdec_side.sv */
// One wheel's 4x decoder: AB state, position, period change and edge counters.
module qdec_side (
  input  logic                     clk,
  input  logic                     rst_n,
  input  qdec_pkg::side_ctl_t      ctl,
  input  logic [1:0]               ab,
  input  logic                     a_edge,
  input  logic                     b_edge,
  input  logic                     reverse,
  output logic signed [31:0]       position,
  output logic signed [31:0]       period_change,
  output logic [31:0]              a_count,
  output logic [31:0]              b_count
);
  import qdec_pkg::*;

  logic [1:0]         prev_ab_r, prev_ab_nxt;
  logic signed [31:0] position_r, position_nxt;
  logic signed [31:0] last_sampled_r, last_sampled_nxt;
  logic signed [31:0] period_change_r, period_change_nxt;
  logic [31:0]        a_count_r, a_count_nxt;
  logic [31:0]        b_count_r, b_count_nxt;
  logic signed [1:0]  step_raw;
  logic signed [1:0]  step_adj;

  always_comb begin
    step_raw = STEP_TABLE[{prev_ab_r, ab}];
    step_adj = reverse ? -step_raw : step_raw;

    prev_ab_nxt       = prev_ab_r;
    position_nxt      = position_r;
    last_sampled_nxt  = last_sampled_r;
    period_change_nxt = period_change_r;
    a_count_nxt       = a_count_r;
    b_count_nxt       = b_count_r;

    if (ctl.pin_event) begin
      a_count_nxt = a_count_r + {31'd0, a_edge};
      b_count_nxt = b_count_r + {31'd0, b_edge};
      // advance only when this side saw an edge
      if (a_edge || b_edge) begin
        position_nxt = position_r + {{30{step_adj[1]}}, step_adj};
        prev_ab_nxt  = ab;
      end
    end else if (ctl.tick) begin
      period_change_nxt = position_r - last_sampled_r;
      last_sampled_nxt  = position_r;
    end else if (ctl.init) begin
      prev_ab_nxt = ab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r       <= 2'd0;
      position_r      <= 32'sd0;
      last_sampled_r  <= 32'sd0;
      period_change_r <= 32'sd0;
      a_count_r       <= 32'd0;
      b_count_r       <= 32'd0;
    end else begin
      prev_ab_r       <= prev_ab_nxt;
      position_r      <= position_nxt;
      last_sampled_r  <= last_sampled_nxt;
      period_change_r <= period_change_nxt;
      a_count_r       <= a_count_nxt;
      b_count_r       <= b_count_nxt;
    end
  end

  assign position      = position_r;
  assign period_change = period_change_r;
  assign a_count       = a_count_r;
  assign b_count       = b_count_r;

endmodule

/* sv/dual_quadrature_decoder.sv */
// Top level: input register, two side decoders, tick counter and result handshake.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    req_type, AB levels, edge flags
//   out_     output     out_valid / out_ready  totals, steps, edge counts, tick number
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data (reverse bits)
//
// A request lands in the input register; once no result waits untaken, the side
// decoders update their state, which drives the result ports directly, and the
// result turns valid with that update: one request per cycle while out_ready is high.
// While a result waits, the state holds and one more request may sit in the
// input register; in_ready follows out_ready through that one stage.
// Synchronous active-low reset clears all counts, totals and valid flags.
module dual_quadrature_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic               in_left_a,
  input  logic               in_left_b,
  input  logic               in_right_a,
  input  logic               in_right_b,
  input  logic               in_left_a_edge,
  input  logic               in_left_b_edge,
  input  logic               in_right_a_edge,
  input  logic               in_right_b_edge,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_left_total,
  output logic signed [31:0] out_right_total,
  output logic signed [31:0] out_left_step,
  output logic signed [31:0] out_right_step,
  output logic [31:0]        out_left_a_count,
  output logic [31:0]        out_left_b_count,
  output logic [31:0]        out_right_a_count,
  output logic [31:0]        out_right_b_count,
  output logic [31:0]        out_tick_number,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data
);
  import qdec_pkg::*;

  logic       in_valid_r;
  logic [1:0] req_r;
  logic [1:0] left_ab_r, right_ab_r;
  logic [3:0] edge_r;   // left A, left B, right A, right B
  logic       out_valid_r;
  logic       left_reverse_r, right_reverse_r;
  logic [31:0] tick_r, tick_nxt;
  logic       advance;
  logic       fire;
  side_ctl_t  ctl;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign fire      = in_valid_r && advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    ctl.pin_event = fire && (req_r == REQ_PIN);
    ctl.tick      = fire && (req_r == REQ_TICK);
    ctl.init      = fire && (req_r == REQ_INIT);
    tick_nxt      = ctl.tick ? tick_r + 32'd1 : tick_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      tick_r          <= 32'd0;
      left_reverse_r  <= 1'b0;
      right_reverse_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= in_valid_r;
      tick_r <= tick_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_LEFT_REVERSE)  left_reverse_r  <= cfg_data;
        if (cfg_index == CFG_RIGHT_REVERSE) right_reverse_r <= cfg_data;
      end
    end
  end

  // hold the request payload until it is processed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r      <= in_req_type;
      left_ab_r  <= {in_left_a, in_left_b};
      right_ab_r <= {in_right_a, in_right_b};
      edge_r     <= {in_left_a_edge, in_left_b_edge, in_right_a_edge, in_right_b_edge};
    end
  end

  qdec_side u_left (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .ab            (left_ab_r),
    .a_edge        (edge_r[3]),
    .b_edge        (edge_r[2]),
    .reverse       (left_reverse_r),
    .position      (out_left_total),
    .period_change (out_left_step),
    .a_count       (out_left_a_count),
    .b_count       (out_left_b_count)
  );

  qdec_side u_right (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .ab            (right_ab_r),
    .a_edge        (edge_r[1]),
    .b_edge        (edge_r[0]),
    .reverse       (right_reverse_r),
    .position      (out_right_total),
    .period_change (out_right_step),
    .a_count       (out_right_a_count),
    .b_count       (out_right_b_count)
  );

  assign out_valid       = out_valid_r;
  assign out_tick_number = tick_r;

endmodule

/* sv/qdec_checker.sv */
// Port-level checks for the dual quadrature decoder, bound to the top level.
module qdec_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_left_total,
  input logic signed [31:0] out_right_total,
  input logic [31:0]        out_left_a_count,
  input logic [31:0]        out_tick_number
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && out_tick_number == 32'd0 && out_left_a_count == 32'd0)
    else $error("reset left a result or count behind");

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $stable(out_tick_number) ||
                     out_tick_number == $past(out_tick_number) + 32'd1)
    else $error("tick number moved by more than one");

  a_tick_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(out_tick_number) |->
      $stable(out_left_total) && $stable(out_right_total) && $stable(out_left_a_count))
    else $error("position or edge count changed on a sample tick");

  a_edge_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $stable(out_left_a_count) ||
                     out_left_a_count == $past(out_left_a_count) + 32'd1)
    else $error("edge count moved by more than one");

endmodule

bind dual_quadrature_decoder qdec_checker u_qdec_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_left_total   (out_left_total),
  .out_right_total  (out_right_total),
  .out_left_a_count (out_left_a_count),
  .out_tick_number  (out_tick_number)
);

/* test/tb.sv */
// Self-checking testbench for the dual quadrature decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qdec_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] req;
    logic       la;
    logic       lb;
    logic       ra;
    logic       rb;
    logic       la_edge;
    logic       lb_edge;
    logic       ra_edge;
    logic       rb_edge;
  } pin_request_t;

  typedef struct {
    logic [31:0] left_total;
    logic [31:0] right_total;
    logic [31:0] left_step;
    logic [31:0] right_step;
    logic [31:0] left_a_count;
    logic [31:0] left_b_count;
    logic [31:0] right_a_count;
    logic [31:0] right_b_count;
    logic [31:0] tick_number;
  } snapshot_t;

  typedef struct {
    logic [1:0] index;
    logic       data;
  } cfg_write_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_req_type;
  logic               in_left_a;
  logic               in_left_b;
  logic               in_right_a;
  logic               in_right_b;
  logic               in_left_a_edge;
  logic               in_left_b_edge;
  logic               in_right_a_edge;
  logic               in_right_b_edge;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_left_total;
  logic signed [31:0] out_right_total;
  logic signed [31:0] out_left_step;
  logic signed [31:0] out_right_step;
  logic [31:0]        out_left_a_count;
  logic [31:0]        out_left_b_count;
  logic [31:0]        out_right_a_count;
  logic [31:0]        out_right_b_count;
  logic [31:0]        out_tick_number;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic               cfg_data;

  // Predicted decoder state
  logic        left_reverse_q;
  logic        right_reverse_q;
  logic [1:0]  left_ab_q;
  logic [1:0]  right_ab_q;
  logic [31:0] left_pos_q;
  logic [31:0] right_pos_q;
  logic [31:0] left_change_q;
  logic [31:0] right_change_q;
  logic [31:0] left_sampled_q;
  logic [31:0] right_sampled_q;
  logic [31:0] edge_count_q [4];
  logic [31:0] tick_count_q;

  snapshot_t   expected_snapshots [$];
  int          mismatches;
  bit          no_gaps;

  // Stimulus-side encoder shafts, tracking what the decoder believes
  logic [1:0]  left_shaft;
  logic [1:0]  right_shaft;
  logic        left_fwd;
  logic        right_fwd;

  dual_quadrature_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_left_a        (in_left_a),
    .in_left_b        (in_left_b),
    .in_right_a       (in_right_a),
    .in_right_b       (in_right_b),
    .in_left_a_edge   (in_left_a_edge),
    .in_left_b_edge   (in_left_b_edge),
    .in_right_a_edge  (in_right_a_edge),
    .in_right_b_edge  (in_right_b_edge),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_total   (out_left_total),
    .out_right_total  (out_right_total),
    .out_left_step    (out_left_step),
    .out_right_step   (out_right_step),
    .out_left_a_count (out_left_a_count),
    .out_left_b_count (out_left_b_count),
    .out_right_a_count(out_right_a_count),
    .out_right_b_count(out_right_b_count),
    .out_tick_number  (out_tick_number),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #200us;
    $display("Verification failed");
    $finish;
  end

  // Signed count change for one AB transition, with polarity applied
  function automatic logic signed [31:0] quad_step(logic [1:0] old_ab, logic [1:0] new_ab,
                                                   logic reverse);
    logic signed [31:0] d;
    case ({old_ab, new_ab})
      4'b0010, 4'b1011, 4'b1101, 4'b0100: d = 32'sd1;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: d = -32'sd1;
      default:                            d = 32'sd0;
    endcase
    return reverse ? -d : d;
  endfunction

  function automatic pin_request_t make_request(logic [1:0] kind, logic [3:0] levels,
                                                logic [3:0] flags);
    return {kind, levels, flags};
  endfunction

  task automatic advance_decoder(input pin_request_t r);
    snapshot_t s;
    case (r.req)
      REQ_PIN: begin
        edge_count_q[0] += r.la_edge;
        edge_count_q[1] += r.lb_edge;
        edge_count_q[2] += r.ra_edge;
        edge_count_q[3] += r.rb_edge;
        if (r.la_edge | r.lb_edge) begin
          left_pos_q = left_pos_q + quad_step(left_ab_q, {r.la, r.lb}, left_reverse_q);
          left_ab_q  = {r.la, r.lb};
        end
        if (r.ra_edge | r.rb_edge) begin
          right_pos_q = right_pos_q + quad_step(right_ab_q, {r.ra, r.rb}, right_reverse_q);
          right_ab_q  = {r.ra, r.rb};
        end
      end
      REQ_TICK: begin
        left_change_q   = left_pos_q - left_sampled_q;
        right_change_q  = right_pos_q - right_sampled_q;
        left_sampled_q  = left_pos_q;
        right_sampled_q = right_pos_q;
        tick_count_q    = tick_count_q + 32'd1;
      end
      REQ_INIT: begin
        left_ab_q  = {r.la, r.lb};
        right_ab_q = {r.ra, r.rb};
      end
      default: ;
    endcase
    s.left_total    = left_pos_q;
    s.right_total   = right_pos_q;
    s.left_step     = left_change_q;
    s.right_step    = right_change_q;
    s.left_a_count  = edge_count_q[0];
    s.left_b_count  = edge_count_q[1];
    s.right_a_count = edge_count_q[2];
    s.right_b_count = edge_count_q[3];
    s.tick_number   = tick_count_q;
    expected_snapshots.push_back(s);
  endtask

  // Leaves in_valid high after the accept; the next call lowers it or reuses it.
  task automatic send_request(input pin_request_t r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= r.req;
    in_left_a       <= r.la;
    in_left_b       <= r.lb;
    in_right_a      <= r.ra;
    in_right_b      <= r.rb;
    in_left_a_edge  <= r.la_edge;
    in_left_b_edge  <= r.lb_edge;
    in_right_a_edge <= r.ra_edge;
    in_right_b_edge <= r.rb_edge;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_decoder(r);
  endtask

  // Hold off requests until every result is back and the pipeline is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_snapshots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input cfg_write_t writes[$]);
    drain_results();
    foreach (writes[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= writes[i].index;
      cfg_data  <= writes[i].data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (writes[i].index)
        CFG_LEFT_REVERSE:  left_reverse_q  = writes[i].data;
        CFG_RIGHT_REVERSE: right_reverse_q = writes[i].data;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_reverse(input logic left_rev, input logic right_rev);
    cfg_write_t writes[$];
    writes.push_back('{CFG_LEFT_REVERSE, left_rev});
    writes.push_back('{CFG_RIGHT_REVERSE, right_rev});
    write_config(writes);
  endtask

  // One side of a pin event: mostly legal quadrature moves, some glitches
  task automatic shaft_move(inout logic [1:0] ab, inout logic fwd,
                            output logic [1:0] levels, output logic [1:0] flags);
    int unsigned pick;
    logic [1:0]  nxt;
    pick  = $urandom_range(0, 9);
    nxt   = ab;
    flags = 2'b00;
    if (pick == 9) fwd = ~fwd;
    if (pick <= 5 || pick == 9) begin
      if ((ab[1] == ab[0]) == fwd) begin
        nxt[1] = ~nxt[1];
        flags  = 2'b10;
      end else begin
        nxt[0] = ~nxt[0];
        flags  = 2'b01;
      end
      if ($urandom_range(0, 4) == 0) flags = 2'b11;
    end else if (pick == 6) begin
      nxt   = ~ab;
      flags = 2'b11;
    end else if (pick == 8) begin
      flags = 2'($urandom_range(1, 3));
    end
    if (pick == 7) begin
      // no flag: levels drift but the decoder must ignore them
      levels = 2'($urandom_range(0, 3));
    end else begin
      levels = nxt;
      ab     = nxt;
    end
  endtask

  task automatic test_operations();
    send_request(make_request(REQ_PIN, 4'b0000, 4'b0000));
    send_request(make_request(REQ_PIN, 4'b1000, 4'b1000));
    send_request(make_request(REQ_PIN, 4'b1101, 4'b0101));
    send_request(make_request(REQ_TICK, 4'b1111, 4'b1111));
    // double changes count zero
    send_request(make_request(REQ_PIN, 4'b0010, 4'b1111));
    send_request(make_request(REQ_UNUSED, 4'b1111, 4'b1111));
    send_request(make_request(REQ_INIT, 4'b1111, 4'b1111));
    send_request(make_request(REQ_PIN, 4'b0110, 4'b1010));
    send_request(make_request(REQ_PIN, 4'b0100, 4'b0100));
    send_request(make_request(REQ_TICK, 4'b0000, 4'b0000));
    send_request(make_request(REQ_PIN, 4'b1111, 4'b1111));
    send_request(make_request(REQ_TICK, 4'b0000, 4'b0000));
  endtask

  task automatic test_reverse();
    cfg_write_t writes[$];
    writes.push_back('{CFG_LEFT_REVERSE, 1'b1});
    writes.push_back('{CFG_RIGHT_REVERSE, 1'b1});
    writes.push_back('{CFG_UNUSED, 1'b1});
    write_config(writes);
    send_request(make_request(REQ_INIT, 4'b0000, 4'b0000));
    send_request(make_request(REQ_PIN, 4'b1010, 4'b1010));
    send_request(make_request(REQ_PIN, 4'b1111, 4'b0101));
    send_request(make_request(REQ_TICK, 4'b0000, 4'b0000));
    set_reverse(1'b0, 1'b1);
    send_request(make_request(REQ_PIN, 4'b0101, 4'b1010));
    send_request(make_request(REQ_PIN, 4'b0000, 4'b0101));
    send_request(make_request(REQ_TICK, 4'b0000, 4'b0000));
  endtask

  task automatic random_phase(input int count);
    pin_request_t r;
    int unsigned  pick;
    logic [1:0]   lv;
    logic [1:0]   fl;
    logic [1:0]   rv;
    logic [1:0]   rf;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      r    = pin_request_t'(10'($urandom));
      if (pick < 8) begin
        r.req = REQ_TICK;
      end else if (pick < 11) begin
        r.req       = REQ_INIT;
        left_shaft  = {r.la, r.lb};
        right_shaft = {r.ra, r.rb};
      end else if (pick < 13) begin
        r.req = REQ_UNUSED;
      end else if (pick < 23) begin
        r.req = REQ_PIN;
        if (r.la_edge | r.lb_edge) left_shaft = {r.la, r.lb};
        if (r.ra_edge | r.rb_edge) right_shaft = {r.ra, r.rb};
      end else begin
        shaft_move(left_shaft, left_fwd, lv, fl);
        shaft_move(right_shaft, right_fwd, rv, rf);
        r = make_request(REQ_PIN, {lv, rv}, {fl, rf});
      end
      send_request(r);
    end
  endtask

  task automatic test_random();
    left_shaft  = left_ab_q;
    right_shaft = right_ab_q;
    left_fwd    = 1'b1;
    right_fwd   = 1'b0;
    set_reverse(1'b0, 1'b0);
    random_phase(120);
    set_reverse(1'b1, 1'b0);
    no_gaps = 1'b1;
    random_phase(100);
    no_gaps = 1'b0;
    set_reverse(1'b0, 1'b1);
    random_phase(100);
    set_reverse(1'b1, 1'b1);
    random_phase(130);
  endtask

  // Result side: random stall before each result, none while no_gaps is set
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    snapshot_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_snapshots.size() == 0) begin
        mismatches++;
        $error("result with no request pending");
      end else begin
        want = expected_snapshots.pop_front();
        check_field("left_total", want.left_total, out_left_total);
        check_field("right_total", want.right_total, out_right_total);
        check_field("left_step", want.left_step, out_left_step);
        check_field("right_step", want.right_step, out_right_step);
        check_field("left_a_count", want.left_a_count, out_left_a_count);
        check_field("left_b_count", want.left_b_count, out_left_b_count);
        check_field("right_a_count", want.right_a_count, out_right_a_count);
        check_field("right_b_count", want.right_b_count, out_right_b_count);
        check_field("tick_number", want.tick_number, out_tick_number);
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_PIN;
    in_left_a       <= 1'b0;
    in_left_b       <= 1'b0;
    in_right_a      <= 1'b0;
    in_right_b      <= 1'b0;
    in_left_a_edge  <= 1'b0;
    in_left_b_edge  <= 1'b0;
    in_right_a_edge <= 1'b0;
    in_right_b_edge <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_LEFT_REVERSE;
    cfg_data        <= 1'b0;
    mismatches      = 0;
    no_gaps         = 1'b0;
    left_reverse_q  = 1'b0;
    right_reverse_q = 1'b0;
    left_ab_q       = 2'b00;
    right_ab_q      = 2'b00;
    left_pos_q      = '0;
    right_pos_q     = '0;
    left_change_q   = '0;
    right_change_q  = '0;
    left_sampled_q  = '0;
    right_sampled_q = '0;
    tick_count_q    = '0;
    foreach (edge_count_q[i]) edge_count_q[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_operations();
    test_reverse();
    test_random();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_snapshots.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/qdec_pkg.sv
sv/qdec_side.sv
sv/dual_quadrature_decoder.sv
sv/qdec_checker.sv
test/tb.sv
